// ===== rtl/core/slrng_pkg.sv =====
package slrng_pkg;

    // value and table geometry
    localparam int unsigned WORD_W    = 30;
    localparam int unsigned SEED_W    = 28;
    localparam int unsigned ADDR_W    = 6;
    localparam int unsigned POS_W     = 7;
    localparam int unsigned PASS_W    = 2;

    typedef logic [WORD_W-1:0] t_word;
    typedef logic [SEED_W-1:0] t_seed;
    typedef logic [ADDR_W-1:0] t_addr;

    localparam t_word MODULUS     = 30'd1000000000;
    localparam t_seed SEED_BASE   = 28'd161803398;
    localparam t_addr TABLE_LEN   = 6'd55;
    localparam t_addr FILL_STRIDE = 6'd21;
    localparam t_addr WARM_OFFSET = 6'd30;
    localparam t_addr LAG_START   = 6'd31;
    localparam t_addr LAST_FILL   = 6'd54;
    localparam logic [PASS_W-1:0] LAST_PASS = 2'd3;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILL,
        ST_WARM_RD,
        ST_WARM_WR,
        ST_DRAW_RD,
        ST_DRAW_WR
    } t_state;

    // subtraction modulo 10^9 for operands already below the modulus
    function automatic t_word mod_sub(input t_word a, input t_word b);
        logic [WORD_W:0] wrap;
        wrap = {1'b0, a} + {1'b0, MODULUS} - {1'b0, b};
        return (a >= b) ? (a - b) : wrap[WORD_W-1:0];
    endfunction

endpackage

// ===== rtl/core/subtractive_lagged_rng.sv =====
// subtractive lagged random generator over a 55-entry table modulo 10^9
//
// input channel: i_valid with i_reseed and i_seed, o_stall back to the
// sender; a request is taken on an edge with i_valid high and o_stall low.
// output channel: o_valid with o_random_value, i_stall from the receiver.
// every request yields exactly one draw.
//
// a plain draw reads two table entries, then subtracts and writes back;
// o_valid rises with that write back, which waits while an earlier draw
// is still stalled in the output register. o_stall is high from acceptance
// until the write back, so the next request waits; all states share the single modulo subtractor.
// a reseed request, and the first request after reset, rebuilds the table
// first: the starting value, a scattered fill of the other 54 entries and
// four warm-up passes over all 55 entries, then the draw as above; o_stall
// stays high until that draw is written back.
//
// reset sets the pointers to 0 and 31 and clears the output valid and the
// seeded flag; the table itself is left as it is and is always rebuilt
// before use.
// while the receiver stalls, the finished draw holds in the output register;
// a following request is still taken and its draw waits before write back.
module subtractive_lagged_rng
    import slrng_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_reseed,
    input  logic [27:0] i_seed,
    output logic        o_stall,
    output logic        o_valid,
    output logic [29:0] o_random_value,
    input  logic        i_stall
);

    // lag table storage
    t_word r_table [0:TABLE_LEN-1];

    t_state r_state, n_state;
    t_addr  r_read, n_read;
    t_addr  r_lag, n_lag;
    logic   r_seeded, n_seeded;
    logic   r_out_valid, n_out_valid;

    t_word  r_cur, n_cur;
    t_word  r_nxt, n_nxt;
    t_addr  r_pos, n_pos;
    t_addr  r_cnt, n_cnt;
    t_addr  r_idx, n_idx;
    logic [PASS_W-1:0] r_pass, n_pass;
    t_word  r_rd_a, r_rd_b;
    t_word  r_random_value, n_random_value;

    logic   accept;
    t_seed  seed_sat;
    t_word  op_a, op_b, diff;
    logic   rd_en;
    t_addr  rd_addr_a, rd_addr_b;
    logic   wr_en;
    t_addr  wr_addr;
    t_word  wr_data;
    logic [POS_W-1:0] pos_sum, warm_sum;
    logic   out_free;

    assign o_stall        = (r_state != ST_IDLE);
    assign o_valid        = r_out_valid;
    assign o_random_value = r_random_value;
    assign accept         = i_valid && (r_state == ST_IDLE);
    assign out_free       = !(r_out_valid && i_stall);

    assign seed_sat = (i_seed > SEED_BASE) ? SEED_BASE : i_seed;

    // shared modulo subtractor operand select
    always_comb begin
        unique case (r_state)
            ST_IDLE: begin
                op_a = {{(WORD_W-SEED_W){1'b0}}, SEED_BASE};
                op_b = {{(WORD_W-SEED_W){1'b0}}, seed_sat};
            end
            ST_FILL: begin
                op_a = r_cur;
                op_b = r_nxt;
            end
            default: begin
                op_a = r_rd_a;
                op_b = r_rd_b;
            end
        endcase
    end

    assign diff = mod_sub(op_a, op_b);

    // stride and lag position arithmetic
    assign pos_sum  = {1'b0, r_pos} + {1'b0, FILL_STRIDE};
    assign warm_sum = {1'b0, r_idx} + {1'b0, WARM_OFFSET};

    // next state and datapath control
    always_comb begin
        n_state        = r_state;
        n_read         = r_read;
        n_lag          = r_lag;
        n_seeded       = r_seeded;
        n_out_valid    = r_out_valid && i_stall;
        n_cur          = r_cur;
        n_nxt          = r_nxt;
        n_pos          = r_pos;
        n_cnt          = r_cnt;
        n_idx          = r_idx;
        n_pass         = r_pass;
        n_random_value = r_random_value;
        rd_en          = 1'b0;
        rd_addr_a      = r_idx - 6'd1;
        rd_addr_b      = (warm_sum >= {1'b0, TABLE_LEN}) ?
                         ADDR_W'(warm_sum - {1'b0, TABLE_LEN}) : ADDR_W'(warm_sum);
        wr_en          = 1'b0;
        wr_addr        = r_idx - 6'd1;
        wr_data        = diff;

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_reseed || !r_seeded) begin
                        // starting value goes to the last entry
                        wr_en   = 1'b1;
                        wr_addr = TABLE_LEN - 6'd1;
                        n_cur   = diff;
                        n_nxt   = 30'd1;
                        n_pos   = FILL_STRIDE;
                        n_cnt   = 6'd1;
                        n_state = ST_FILL;
                    end else begin
                        n_read  = (r_read >= TABLE_LEN) ? 6'd1 : r_read + 6'd1;
                        n_lag   = (r_lag >= TABLE_LEN) ? 6'd1 : r_lag + 6'd1;
                        n_state = ST_DRAW_RD;
                    end
                end
            end
            ST_FILL: begin
                // scattered fill at stride 21
                wr_en   = 1'b1;
                wr_addr = r_pos - 6'd1;
                wr_data = r_nxt;
                n_nxt   = diff;
                n_cur   = r_nxt;
                n_pos   = (pos_sum >= {1'b0, TABLE_LEN}) ?
                          ADDR_W'(pos_sum - {1'b0, TABLE_LEN}) : ADDR_W'(pos_sum);
                if (r_cnt == LAST_FILL) begin
                    n_idx   = 6'd1;
                    n_pass  = '0;
                    n_state = ST_WARM_RD;
                end else begin
                    n_cnt = r_cnt + 6'd1;
                end
            end
            ST_WARM_RD: begin
                rd_en   = 1'b1;
                n_state = ST_WARM_WR;
            end
            ST_WARM_WR: begin
                // entry minus the one 31 places on
                wr_en = 1'b1;
                if (r_idx == TABLE_LEN) begin
                    n_idx = 6'd1;
                    if (r_pass == LAST_PASS) begin
                        n_read   = 6'd1;
                        n_lag    = LAG_START + 6'd1;
                        n_seeded = 1'b1;
                        n_state  = ST_DRAW_RD;
                    end else begin
                        n_pass  = r_pass + 2'd1;
                        n_state = ST_WARM_RD;
                    end
                end else begin
                    n_idx   = r_idx + 6'd1;
                    n_state = ST_WARM_RD;
                end
            end
            ST_DRAW_RD: begin
                rd_en     = 1'b1;
                rd_addr_a = r_read - 6'd1;
                rd_addr_b = r_lag - 6'd1;
                n_state   = ST_DRAW_WR;
            end
            ST_DRAW_WR: begin
                // write back and present once the output register is free
                wr_addr = r_read - 6'd1;
                if (out_free) begin
                    wr_en          = 1'b1;
                    n_random_value = diff;
                    n_out_valid    = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_read      <= '0;
            r_lag       <= LAG_START;
            r_seeded    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_read      <= n_read;
            r_lag       <= n_lag;
            r_seeded    <= n_seeded;
            r_out_valid <= n_out_valid;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_cur          <= n_cur;
        r_nxt          <= n_nxt;
        r_pos          <= n_pos;
        r_cnt          <= n_cnt;
        r_idx          <= n_idx;
        r_pass         <= n_pass;
        r_random_value <= n_random_value;
    end

    // table write port and registered reads
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_table[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_a <= r_table[rd_addr_a];
            r_rd_b <= r_table[rd_addr_b];
        end
    end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import slrng_pkg::*;

    // block ports
    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        i_valid  = 1'b0;
    logic        i_reseed = 1'b0;
    logic [27:0] i_seed   = '0;
    logic        i_stall  = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [29:0] o_random_value;

    // generator mirror: positions 1..55, pointers and seeded flag
    t_word       lag_words [1:55];
    int unsigned rd_pos;
    int unsigned lag_pos;
    bit          table_ready;

    // draws predicted but not yet seen on the output
    t_word       pending_draws [$];

    int unsigned n_requests;
    int unsigned n_reseeds;
    int unsigned n_draws;
    int unsigned n_errors;
    int unsigned stall_left;
    bit          quiet;

    subtractive_lagged_rng u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .i_reseed       (i_reseed),
        .i_seed         (i_seed),
        .o_stall        (o_stall),
        .o_valid        (o_valid),
        .o_random_value (o_random_value),
        .i_stall        (i_stall)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // a - b modulo 10^9, both below the modulus
    function automatic t_word sub_mod_billion(input t_word a, input t_word b);
        int unsigned wide_a;
        wide_a = a;
        if (a >= b) begin
            return t_word'(a - b);
        end
        return t_word'(wide_a + MODULUS - b);
    endfunction

    // rebuild the lag table from a seed: scattered fill, then four warm-up passes
    function automatic void rebuild_from_seed(input t_seed seed);
        t_seed       clipped;
        t_word       cur;
        t_word       nxt;
        int unsigned pos;
        clipped = (seed > SEED_BASE) ? SEED_BASE : seed;
        cur = t_word'(SEED_BASE - clipped);
        nxt = 1;
        lag_words[TABLE_LEN] = cur;
        for (int unsigned k = 1; k < TABLE_LEN; k++) begin
            pos = (FILL_STRIDE * k) % TABLE_LEN;
            lag_words[pos] = nxt;
            nxt = sub_mod_billion(cur, nxt);
            cur = lag_words[pos];
        end
        for (int unsigned pass = 0; pass < 4; pass++) begin
            for (int unsigned k = 1; k <= TABLE_LEN; k++) begin
                lag_words[k] = sub_mod_billion(lag_words[k],
                                               lag_words[1 + (k + WARM_OFFSET) % TABLE_LEN]);
            end
        end
        rd_pos      = 0;
        lag_pos     = LAG_START;
        table_ready = 1'b1;
    endfunction

    // advance both pointers and write the new entry back
    function automatic t_word next_draw();
        t_word v;
        rd_pos  = (rd_pos >= TABLE_LEN) ? 1 : rd_pos + 1;
        lag_pos = (lag_pos >= TABLE_LEN) ? 1 : lag_pos + 1;
        v = sub_mod_billion(lag_words[rd_pos], lag_words[lag_pos]);
        lag_words[rd_pos] = v;
        return v;
    endfunction

    // mostly in-range seeds, a quarter across all 28 bits
    function automatic t_seed pick_seed();
        if ($urandom_range(0, 3) == 0) begin
            return t_seed'($urandom);
        end
        return t_seed'($urandom_range(0, SEED_BASE));
    endfunction

    task automatic report_mismatch(input string what, input t_word got, input t_word want);
        $display("%0t ns: mismatch, %s: got %0d, want %0d", $time, what, got, want);
        n_errors++;
    endtask

    // send one request after a random gap and predict its draw on acceptance
    task automatic send_request(input bit reseed, input t_seed seed);
        int unsigned gap;
        gap = quiet ? 0 : $urandom_range(0, 7);
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid  <= 1'b1;
        i_reseed <= reseed;
        i_seed   <= seed;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        if (reseed || !table_ready) begin
            rebuild_from_seed(seed);
        end
        pending_draws.push_back(next_draw());
        n_requests++;
        if (reseed) begin
            n_reseeds++;
        end
    endtask

    // output side: check each accepted draw, then stall at random
    always begin
        @(posedge i_clk);
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_draws.size() == 0) begin
                report_mismatch("draw with nothing pending", o_random_value, '0);
            end else begin
                t_word want;
                want = pending_draws.pop_front();
                if (o_random_value !== want) begin
                    report_mismatch("random_value", o_random_value, want);
                end
            end
            n_draws++;
            stall_left = quiet ? 0 : $urandom_range(0, 7);
        end
        @(negedge i_clk);
        i_stall <= (stall_left > 0);
        if (stall_left > 0) begin
            stall_left--;
        end
    end

    // first request after reset rebuilds even without reseed
    task automatic test_first_request();
        send_request(1'b0, 28'd314159);
        send_request(1'b0, 28'd271828);
    endtask

    // seed bounds, saturation above range, alternating bit patterns
    task automatic test_seed_extremes();
        t_seed seeds [6];
        seeds = '{28'd0, SEED_BASE, SEED_BASE + 28'd1, 28'hFFFFFFF, 28'h5555555, 28'hAAAAAAA};
        foreach (seeds[k]) begin
            send_request(1'b1, seeds[k]);
            send_request(1'b0, ~seeds[k]);
        end
    endtask

    // seed has no effect on plain draws, back to back
    task automatic test_seed_ignored();
        quiet = 1'b1;
        send_request(1'b0, 28'd0);
        send_request(1'b0, 28'hFFFFFFF);
        send_request(1'b0, pick_seed());
        quiet = 1'b0;
    endtask

    // reseed then long plain runs that wrap the pointers, plus noisy bursts
    task automatic test_random_sequences();
        int unsigned run_len;
        while (n_requests < 1700) begin
            quiet = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 4) != 0) begin
                send_request(1'b1, pick_seed());
                run_len = $urandom_range(0, 120);
                repeat (run_len) send_request(1'b0, pick_seed());
            end else begin
                run_len = $urandom_range(1, 12);
                repeat (run_len) send_request(bit'($urandom_range(0, 1)), pick_seed());
            end
        end
        quiet = 1'b0;
    endtask

    // main sequence
    initial begin
        foreach (lag_words[k]) begin
            lag_words[k] = '0;
        end
        rd_pos      = 0;
        lag_pos     = LAG_START;
        table_ready = 1'b0;
        n_requests  = 0;
        n_reseeds   = 0;
        n_draws     = 0;
        n_errors    = 0;
        stall_left  = 0;
        quiet       = 1'b0;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_first_request();
        test_seed_extremes();
        test_seed_ignored();
        test_random_sequences();

        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_draws.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("run covered %0d requests, %0d of them reseeds, and %0d checked draws",
                 n_requests, n_reseeds, n_draws);
        $display("seed bounds, saturation, ignored seeds and pointer wrap included; %0d mismatches",
                 n_errors);
        if (n_errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // watchdog
    initial begin
        #60000000;
        $display("timeout with %0d draws still pending", pending_draws.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule
